@@ rtl/ntrm_pkg.sv @@
`default_nettype none

package ntrm_pkg;

  // action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // vertex orders
  localparam logic [1:0] ROT_ABC = 2'd0;
  localparam logic [1:0] ROT_BCA = 2'd1;
  localparam logic [1:0] ROT_CAB = 2'd2;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SqW    = 32;  // (2^16 - 1)^2 fits unsigned 32 bits
  localparam int unsigned PairW  = 34;  // three squares
  localparam int unsigned DistW  = 36;  // nine squares

  // triangle as [vertex][coord], vertex 0..2 = a..c, coord 0..2 = x..z
  typedef logic [2:0][2:0][CoordW-1:0] tri_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [7:0]       best_index;
    logic [1:0]       rotation;
    logic [DistW-1:0] best_distance;
    logic             store_full;
    logic [8:0]       stored_count;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/nearest_triangle_rotation_match_top.sv @@
`default_nettype none

// Nearest candidate triangle search with cyclic vertex-order matching.
//
// Input word: start is a request, taken at a rising edge with start high and
// busy low. req_i.action picks clear (empty the store), append (store the
// triangle in req_i) or query (find the stored triangle nearest to req_i).
// Output word: done_o is high for exactly one cycle with rsp_o valid; the
// receiver cannot stall, so it must take the word in that cycle.
//
// Clear, append and unused codes: one word, the cycle after acceptance; busy
// stays low, so another word may be started right away.
// Query: busy is high while the store is swept. One candidate per cycle is
// read from the candidate memory (one read port, registered data), then a
// six-stage pipeline forms 27 coordinate differences, squares them, sums per
// vertex pair, per vertex order, picks the best order and updates the running
// best. done_o for a query follows once every stored candidate has passed the
// pipeline, also for an empty store; busy falls with done_o.
// Reset clears the candidate count; the memory itself is not cleared, and
// only entries below the count are ever used.
module nearest_triangle_rotation_match_top
  import ntrm_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  output logic       busy,
  input  in_word_t   req_i,
  output logic       done_o,
  output out_word_t  rsp_o
);

  localparam int unsigned AW     = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int unsigned CW     = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned Stages = 6;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_QUERY = 1'b1;

  logic state_q, state_d;

  // candidate memory
  tri_t mem_q [MAX_CANDIDATES];
  tri_t rdata_q;

  logic [CW-1:0] count_q;
  logic [CW-1:0] ptr_q;
  tri_t          ref_q;
  tri_t          req_tri;

  logic accept, issue, drained, sweep_done, is_full;

  // pipeline
  logic [Stages-1:0]       v_q;
  logic [AW-1:0]           idx_q [Stages];
  logic signed [CoordW:0]  diff_q [3][3][3];   // [cand vertex][ref vertex][coord]
  logic signed [CoordW:0]  diff_d [3][3][3];
  logic [SqW-1:0]          sq_q [3][3][3];
  logic [SqW-1:0]          sq_d [3][3][3];
  logic [2*CoordW+1:0]     prod [3][3][3];
  logic [PairW-1:0]        pd_q [3][3];
  logic [PairW-1:0]        pd_d [3][3];
  logic [DistW-1:0]        od_q [3];
  logic [DistW-1:0]        od_d [3];
  logic [DistW-1:0]        md_q, md_d;
  logic [1:0]              mr_q, mr_d;

  // running best
  logic             have_q;
  logic [DistW-1:0] best_q;
  logic [AW-1:0]    best_idx_q;
  logic [1:0]       best_rot_q;

  out_word_t rsp_q, rsp_d;
  logic      done_q, done_d;

  assign busy    = (state_q == ST_QUERY);
  assign accept  = start && !busy;
  assign is_full = (count_q == CW'(MAX_CANDIDATES));
  assign issue   = (state_q == ST_QUERY) && (ptr_q < count_q);
  assign drained = (v_q == '0);
  assign sweep_done = (state_q == ST_QUERY) && !issue && drained;

  assign req_tri = {req_i.cz, req_i.cy, req_i.cx,
                    req_i.bz, req_i.by, req_i.bx,
                    req_i.az, req_i.ay, req_i.ax};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i.action == ACT_QUERY) state_d = ST_QUERY;
      end
      ST_QUERY: begin
        if (sweep_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (accept && req_i.action == ACT_APPEND && !is_full) begin
      mem_q[count_q[AW-1:0]] <= req_tri;
    end
    rdata_q <= mem_q[ptr_q[AW-1:0]];
  end

  // datapath stages
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          diff_d[i][j][k] = $signed({rdata_q[i][k][CoordW-1], rdata_q[i][k]})
                          - $signed({ref_q[j][k][CoordW-1], ref_q[j][k]});
          prod[i][j][k]   = diff_q[i][j][k] * diff_q[i][j][k];
          sq_d[i][j][k]   = prod[i][j][k][SqW-1:0];
        end
        pd_d[i][j] = PairW'(sq_q[i][j][0]) + PairW'(sq_q[i][j][1])
                   + PairW'(sq_q[i][j][2]);
      end
    end
    // order o pairs reference vertex j with candidate vertex (j + o) mod 3
    for (int o = 0; o < 3; o++) begin
      od_d[o] = DistW'(pd_q[o % 3][0]) + DistW'(pd_q[(o + 1) % 3][1])
              + DistW'(pd_q[(o + 2) % 3][2]);
    end
    md_d = od_q[0];
    mr_d = ROT_ABC;
    if (od_q[1] < md_d) begin
      md_d = od_q[1];
      mr_d = ROT_BCA;
    end
    if (od_q[2] < md_d) begin
      md_d = od_q[2];
      mr_d = ROT_CAB;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= sq_d;
    pd_q   <= pd_d;
    od_q   <= od_d;
    md_q   <= md_d;
    mr_q   <= mr_d;
    idx_q[0] <= ptr_q[AW-1:0];
    for (int s = 1; s < Stages; s++) begin
      idx_q[s] <= idx_q[s-1];
    end
    if (accept && req_i.action == ACT_QUERY) begin
      ref_q <= req_tri;
    end
    if (v_q[Stages-1] && (!have_q || md_q < best_q)) begin
      best_q     <= md_q;
      best_idx_q <= idx_q[Stages-1];
      best_rot_q <= mr_q;
    end
  end

  // response word
  always_comb begin
    done_d = 1'b0;
    rsp_d  = rsp_q;
    if (accept) begin
      rsp_d = '0;
      case (req_i.action)
        ACT_CLEAR: begin
          rsp_d.stored_count = '0;
          done_d = 1'b1;
        end
        ACT_APPEND: begin
          rsp_d.store_full   = is_full;
          rsp_d.stored_count = is_full ? 9'(count_q) : 9'(count_q + 1'b1);
          done_d = 1'b1;
        end
        ACT_QUERY: ;
        default: begin
          rsp_d.stored_count = 9'(count_q);
          done_d = 1'b1;
        end
      endcase
    end
    if (sweep_done) begin
      done_d              = 1'b1;
      rsp_d.found         = have_q;
      rsp_d.best_index    = have_q ? 8'(best_idx_q) : 8'd0;
      rsp_d.rotation      = have_q ? best_rot_q : ROT_ABC;
      rsp_d.best_distance = have_q ? best_q : '0;
      rsp_d.store_full    = 1'b0;
      rsp_d.stored_count  = 9'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      v_q     <= '0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      v_q     <= {v_q[Stages-2:0], issue};
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      if (issue) ptr_q <= ptr_q + 1'b1;
      if (v_q[Stages-1]) have_q <= 1'b1;

      if (accept) begin
        case (req_i.action)
          ACT_CLEAR: begin
            count_q <= '0;
          end
          ACT_APPEND: begin
            if (!is_full) begin
              count_q <= count_q + 1'b1;
            end
          end
          ACT_QUERY: begin
            ptr_q  <= '0;
            have_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ rtl/ntrm_checker.sv @@
`default_nettype none

module ntrm_checker
  import ntrm_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input in_word_t  req_i,
  input wire       done_o,
  input out_word_t rsp_o
);

  // a rejected append never reports a match
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.store_full |-> !rsp_o.found)
    else $error("store_full together with found");

  // no match means all match fields are zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.found |->
      rsp_o.best_index == 8'd0 && rsp_o.rotation == ROT_ABC &&
      rsp_o.best_distance == '0)
    else $error("match fields set without a match");

  // store operations answer in the next cycle
  a_store_op_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.action != ACT_QUERY |=> done_o)
    else $error("missing word after store operation");

  // end of a sweep comes with its word
  a_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a word");

  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (MAX_CANDIDATES >= 512) ||
               (32'(rsp_o.stored_count) <= MAX_CANDIDATES))
    else $error("stored_count beyond store depth");

endmodule

bind nearest_triangle_rotation_match_top ntrm_checker #(
  .MAX_CANDIDATES(MAX_CANDIDATES)
) u_ntrm_checker (.*);

`default_nettype wire

@@ bench/nearest_triangle_rotation_match_top_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the nearest triangle search.
// The driver feeds command words from a queue; every accepted word is run
// through a local predictor of the store and the sweep, and the monitor
// checks each done_o word against the oldest prediction.
module nearest_triangle_rotation_match_top_tb;
  import ntrm_pkg::*;

  localparam int MAX_CAND     = 256;
  localparam int RANDOM_WORDS = 1150;
  localparam int TAIL_CYCLES  = 300;      // covers the longest sweep, over a full store
  localparam int LIMIT        = 2000000;  // far beyond the slowest correct run
  localparam int MAX_REPORTS  = 10;

  // the fourth action code has no name in the package; the block ignores it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // nine coordinates of a triangle as they sit in the word: [8] is ax, [0] is cz
  typedef logic [8:0][CoordW-1:0] coords_t;

  // one queued command word; hold makes the driver wait for a drained block
  typedef struct packed {
    logic       hold;
    logic [3:0] idle_after;
    in_word_t   word;
  } pend_item_t;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      start    = 1'b0;
  in_word_t  req_word = '0;
  logic      busy;
  logic      done_o;
  out_word_t rsp_o;

  // predictor copy of the block state
  coords_t cand_mem [MAX_CAND];
  int      stored_n = 0;

  // generator shadow of the store, used to aim queries at stored triangles
  coords_t gen_tris [MAX_CAND];
  int      gen_count    = 0;
  int      words_queued = 0;
  logic    idle_on      = 1'b0;
  logic    hold_next    = 1'b0;

  pend_item_t pend_q[$];
  out_word_t  expected_rsp_q[$];

  int words_sent   = 0;
  int results_seen = 0;
  int error_count  = 0;
  int idle_left    = 0;
  int cycle_count  = 0;

  // run statistics
  int n_clears   = 0;
  int n_appends  = 0;
  int n_refused  = 0;
  int n_queries  = 0;
  int n_hits     = 0;
  int n_rot_abc  = 0;
  int n_rot_bca  = 0;
  int n_rot_cab  = 0;

  nearest_triangle_rotation_match_top #(
    .MAX_CANDIDATES(MAX_CAND)
  ) DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i (req_word),
    .done_o,
    .rsp_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Vertex v of the result is vertex (v + o) mod 3 of c: o = 1 gives bca, 2 gives cab.
  function automatic coords_t rotate_coords(coords_t c, int o);
    coords_t r;
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++)
        r[8 - (v * 3 + k)] = c[8 - (((v + o) % 3) * 3 + k)];
    return r;
  endfunction

  // Predicts the response to one accepted word and advances the store copy.
  function automatic out_word_t predict_match(in_word_t w);
    out_word_t  r;
    coords_t    refc;
    coords_t    rc;
    longint     d;
    longint     sum;
    longint     cand_best;
    longint     best;
    logic [1:0] cand_rot;
    logic       have;
    r    = '0;
    refc = w[9*CoordW-1:0];
    case (w.action)
      ACT_CLEAR: begin
        stored_n = 0;
        n_clears++;
      end
      ACT_APPEND: begin
        n_appends++;
        if (stored_n >= MAX_CAND) begin
          r.store_full = 1'b1;
          n_refused++;
        end else begin
          cand_mem[stored_n] = refc;
          stored_n++;
        end
      end
      ACT_QUERY: begin
        n_queries++;
        have = 1'b0;
        best = 0;
        for (int i = 0; i < stored_n; i++) begin
          cand_best = 0;
          cand_rot  = ROT_ABC;
          for (int o = 0; o < 3; o++) begin
            rc  = rotate_coords(cand_mem[i], o);
            sum = 0;
            for (int j = 0; j < 9; j++) begin
              d   = longint'($signed(rc[j])) - longint'($signed(refc[j]));
              sum = sum + d * d;
            end
            // strict compare: earlier order keeps a tie
            if (o == 0 || sum < cand_best) begin
              cand_best = sum;
              cand_rot  = (o == 0) ? ROT_ABC : (o == 1) ? ROT_BCA : ROT_CAB;
            end
          end
          // strict compare: lower index keeps a tie
          if (!have || cand_best < best) begin
            have         = 1'b1;
            best         = cand_best;
            r.best_index = 8'(i);
            r.rotation   = cand_rot;
          end
        end
        if (have) begin
          r.found         = 1'b1;
          r.best_distance = best[DistW-1:0];
          n_hits++;
          case (r.rotation)
            ROT_ABC: n_rot_abc++;
            ROT_BCA: n_rot_bca++;
            default: n_rot_cab++;
          endcase
        end
      end
      default: ;
    endcase
    r.stored_count = 9'(stored_n);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s", $time, msg);
  endtask

  // clustered triangles put candidates close together so the search is tight
  function automatic coords_t rand_coords(int clustered);
    coords_t     c;
    logic [15:0] base;
    base = 16'($urandom);
    for (int j = 0; j < 9; j++)
      c[j] = clustered ? base + 16'($urandom_range(0, 1023)) : 16'($urandom);
    return c;
  endfunction

  // Query reference: mostly a stored triangle in some order, often nudged a bit.
  function automatic coords_t near_coords();
    coords_t c;
    if (gen_count == 0 || $urandom_range(0, 3) == 0)
      return rand_coords($urandom_range(0, 1));
    c = rotate_coords(gen_tris[$urandom_range(0, gen_count - 1)], $urandom_range(0, 2));
    if ($urandom_range(0, 2) != 0)
      for (int j = 0; j < 9; j++)
        c[j] = c[j] + 16'($urandom_range(0, 64)) - 16'd32;
    return c;
  endfunction

  task automatic queue_word(input logic [1:0] act, input coords_t c);
    pend_item_t item;
    item.hold       = hold_next;
    item.idle_after = (idle_on && $urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 12)) : 4'd0;
    item.word       = {act, c};
    pend_q = {pend_q, item};
    hold_next = 1'b0;
    if (act == ACT_CLEAR) begin
      gen_count = 0;
    end else if (act == ACT_APPEND && gen_count < MAX_CAND) begin
      gen_tris[gen_count] = c;
      gen_count++;
    end
    if (act != ACT_UNUSED)
      words_queued++;
  endtask

  // Driver: a word is taken at an edge with start high and busy low. The next
  // word follows at once unless an idle burst or a drain hold is pending.
  // Idle cycles only count down while busy is low, so gaps also land right
  // after a sweep ends.
  always @(posedge clk_i) begin : drive_proc
    pend_item_t item;
    logic       nxt_start;
    in_word_t   nxt_word;
    nxt_start = start;
    nxt_word  = req_word;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsp_q = {expected_rsp_q, predict_match(req_word)};
        words_sent <= words_sent + 1;
        nxt_start = 1'b0;
      end
      if (!nxt_start && pend_q.size() > 0) begin
        if (idle_left > 0) begin
          if (!busy)
            idle_left--;
        end else if (!pend_q[0].hold || (!start && words_sent == results_seen)) begin
          item      = pend_q.pop_front();
          nxt_word  = item.word;
          nxt_start = 1'b1;
          idle_left = item.idle_after;
        end
      end
    end
    start    <= nxt_start;
    req_word <= nxt_word;
  end

  // Monitor: done_o words cannot be held off, so each one is checked in the
  // cycle it shows. Counters are updated by nonblocking writes, so a word
  // predicted at this same edge is never taken for this result.
  always @(posedge clk_i) begin : check_proc
    out_word_t want;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (results_seen >= words_sent) begin
        flag_error($sformatf("result with no word outstanding: found=%0b idx=%0d rot=%0d",
                             rsp_o.found, rsp_o.best_index, rsp_o.rotation));
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.found !== want.found || rsp_o.best_index !== want.best_index ||
            rsp_o.rotation !== want.rotation || rsp_o.best_distance !== want.best_distance ||
            rsp_o.store_full !== want.store_full ||
            rsp_o.stored_count !== want.stored_count)
          flag_error($sformatf({"result %0d mismatch: want found=%0b idx=%0d rot=%0d ",
                                "dist=%0d full=%0b count=%0d, got found=%0b idx=%0d ",
                                "rot=%0d dist=%0d full=%0b count=%0d"},
                               results_seen, want.found, want.best_index, want.rotation,
                               want.best_distance, want.store_full, want.stored_count,
                               rsp_o.found, rsp_o.best_index, rsp_o.rotation,
                               rsp_o.best_distance, rsp_o.store_full, rsp_o.stored_count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, results_seen, words_sent);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim_proc
    coords_t          t;
    coords_t          v;
    logic [2:0][15:0] vx;
    int               k;
    int               q;
    int               pick;
    int               episode;

    // ---- directed words ----
    queue_word(ACT_QUERY, rand_coords(0));          // query on the empty store
    queue_word(ACT_APPEND, {9{16'h8000}});          // most negative corner
    queue_word(ACT_QUERY, {9{16'h7fff}});           // largest possible distance
    queue_word(ACT_APPEND, {9{16'h7fff}});          // most positive corner
    queue_word(ACT_QUERY, {9{16'h7fff}});
    queue_word(ACT_QUERY, {9{16'h8000}});
    queue_word(ACT_QUERY, {9{16'h0000}});
    queue_word(ACT_QUERY, {9{16'h5555}});
    queue_word(ACT_QUERY, {9{16'haaaa}});
    queue_word(ACT_CLEAR, rand_coords(0));          // coordinates ignored on clear
    queue_word(ACT_QUERY, rand_coords(0));          // empty again after clear
    queue_word(ACT_UNUSED, rand_coords(0));         // ignored code must not append
    queue_word(ACT_QUERY, rand_coords(0));
    t = rand_coords(0);
    queue_word(ACT_APPEND, t);                      // index 0
    queue_word(ACT_APPEND, rotate_coords(t, 1));    // index 1: same triangle, bca order
    queue_word(ACT_APPEND, t);                      // index 2: duplicate of index 0
    queue_word(ACT_QUERY, t);                       // exact hit ties the duplicate
    queue_word(ACT_QUERY, rotate_coords(t, 1));     // index 0 bca ties index 1 abc
    queue_word(ACT_QUERY, rotate_coords(t, 2));     // index 0 cab
    vx = {16'($urandom), 16'($urandom), 16'($urandom)};
    v  = {vx, vx, vx};
    queue_word(ACT_APPEND, v);                      // three equal vertices
    queue_word(ACT_QUERY, v);                       // all three orders tie
    queue_word(ACT_QUERY, near_coords());

    // ---- random episodes ----
    words_queued = 0;
    hold_next    = 1'b1;                            // drain before the random part
    episode      = 0;
    while (words_queued < RANDOM_WORDS) begin
      idle_on   = (words_queued < RANDOM_WORDS - 150) && ($urandom_range(0, 3) != 0);
      hold_next = hold_next || ((words_queued < RANDOM_WORDS - 150) &&
                                ($urandom_range(0, 7) == 0));
      pick      = $urandom_range(0, 19);
      if (episode == 3 || episode == 25) begin
        // fill to capacity, try a few refused appends, then sweep the full store
        queue_word(ACT_CLEAR, rand_coords(0));
        for (k = 0; k < MAX_CAND; k++)
          queue_word(ACT_APPEND, rand_coords($urandom_range(0, 1)));
        for (k = $urandom_range(1, 3); k > 0; k--)
          queue_word(ACT_APPEND, rand_coords(0));
        queue_word(ACT_QUERY, gen_tris[MAX_CAND - 1]);
        for (q = 0; q < 3; q++)
          queue_word(ACT_QUERY, near_coords());
      end else if (pick < 14) begin
        // well-formed: optional clear, a batch of appends, then queries
        if ($urandom_range(0, 2) != 0)
          queue_word(ACT_CLEAR, rand_coords(0));
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 48) : $urandom_range(1, 8);
        for (; k > 0; k--) begin
          if (gen_count > 0 && $urandom_range(0, 5) == 0)
            queue_word(ACT_APPEND, rotate_coords(gen_tris[$urandom_range(0, gen_count - 1)],
                                                 $urandom_range(0, 2)));
          else
            queue_word(ACT_APPEND, rand_coords($urandom_range(0, 1)));
        end
        for (q = $urandom_range(1, 4); q > 0; q--)
          queue_word(ACT_QUERY, near_coords());
      end else if (pick < 17) begin
        // noise: any action code, random content
        for (q = $urandom_range(1, 4); q > 0; q--)
          queue_word(2'($urandom), rand_coords(0));
      end else begin
        // broken order: queries, clears and appends interleaved
        for (q = $urandom_range(4, 10); q > 0; q--) begin
          k = $urandom_range(0, 19);
          queue_word((k < 10) ? ACT_APPEND : (k < 17) ? ACT_QUERY : ACT_CLEAR,
                     (k >= 10 && k < 17) ? near_coords() : rand_coords($urandom_range(0, 1)));
        end
      end
      episode++;
    end

    // ---- reset, then let the driver run ----
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() != 0 || start || words_sent != results_seen)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (words_sent != results_seen)
      flag_error($sformatf("%0d results never arrived", words_sent - results_seen));

    $display("covered %0d words: %0d clears, %0d appends (%0d refused on a full store), %0d queries",
             words_sent, n_clears, n_appends, n_refused, n_queries);
    $display("query hits %0d, best order abc %0d bca %0d cab %0d, mismatches %0d",
             n_hits, n_rot_abc, n_rot_bca, n_rot_cab, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
